@@ rtl/heating_drive_scheduler_macros.svh @@
// Assertion macros for the heating drive scheduler.
// Used by the top level; expects signals clk and rst in scope.
`ifndef HEATING_DRIVE_SCHEDULER_MACROS_SVH
`define HEATING_DRIVE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define HDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heating drive scheduler: check failed");

// next-cycle implication
`define HDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heating drive scheduler: check failed");

`endif

@@ rtl/hds_pkg.sv @@
// Shared types and constants of the heating drive scheduler.
// No dependencies.
package hds_pkg;

  localparam int TEMP_W = 12;
  localparam int PCT_W  = 7;
  localparam int NUM_W  = 19;   // product of a 12 bit operand and a 7 bit operand
  localparam int MPL_W  = 7;
  localparam int DIV_W  = 12;
  localparam int CNT_W  = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_CRIT    = 7'd80;
  localparam logic [PCT_W-1:0]  FAN_WIN_TOP = 7'd40;
  localparam logic [MPL_W-1:0]  WIN_SCALE   = 7'd100;
  localparam logic [DIV_W-1:0]  WIN_DIV     = 12'd100;
  localparam logic [DIV_W-1:0]  DEFICIT_MAX = 12'd20;

  localparam logic                     RST_HEAT_EN  = 1'b1;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_MIN = 12'sd250;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_MAX = 12'sd260;
  localparam logic [PCT_W-1:0]         RST_PUMP_MIN = 7'd20;
  localparam logic [PCT_W-1:0]         RST_PUMP_MAX = 7'd100;
  localparam logic [PCT_W-1:0]         RST_FAN_MIN  = 7'd20;
  localparam logic [PCT_W-1:0]         RST_FAN_MAX  = 7'd100;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_AUTO   = 2'd1,
    OP_MANUAL = 2'd2,
    OP_FORCE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_HEAT_EN  = 3'd0,
    REG_TEMP_MIN = 3'd1,
    REG_TEMP_MAX = 3'd2,
    REG_PUMP_MIN = 3'd3,
    REG_PUMP_MAX = 3'd4,
    REG_FAN_MIN  = 3'd5,
    REG_FAN_MAX  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WIN,
    S_LERP,
    S_WRITE
  } sched_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

  // request to the serial multiply-divide unit: q = (a * b) / c
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   a;
    logic [MPL_W-1:0]   b;
    logic [DIV_W-1:0]   c;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] q;
  } md_rsp_t;

endpackage

@@ rtl/heating_drive_scheduler.sv @@
// Heating drive scheduler top level: register port, mode latches, drive sequencer.
// Depends on hds_pkg, hds_muldiv and heating_drive_scheduler_macros.svh.
//
// Each input word is a mode command or a room temperature sample; each gives one
// result word carrying the drive (when drive_valid is set) and the three latches as
// they stand after it. Commands, ignored samples and the fixed cases (emergency,
// critical, above the upper limit) go from acceptance to the output register
// through the decide and write steps. A sample below the lower limit needs one pass
// of the bit-serial multiply-divide pair (decide, pass, finish, write). A sample
// inside the comfort window needs two passes (window position, then the two
// ramps), or one for an empty window. Each pass is 7 multiply steps plus 19 divide
// steps of hds_muldiv. One word is in work at a time and the input stalls from
// acceptance until the result is loaded; the next word is taken in the cycle after
// that. The output register lets the next word be accepted while a result waits; a
// further result then holds in the write step until the waiting one leaves.
// Configuration may be written only while the block is idle.
module heating_drive_scheduler #(
  parameter int EMERGENCY_LOW = 50,
  parameter int CRITICAL_LOW  = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hds_pkg::ADDR_W-1:0]      paddr,
  input  logic [hds_pkg::DATA_W-1:0]      pwdata,
  output logic [hds_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic signed [hds_pkg::TEMP_W-1:0] temp_room,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            drive_valid,
  output logic [hds_pkg::PCT_W-1:0]       pump_percent,
  output logic [hds_pkg::PCT_W-1:0]       fan_percent,
  output logic                            manual_flag,
  output logic                            force_flag,
  output logic                            emergency_flag
);

`include "heating_drive_scheduler_macros.svh"

  localparam int TW = hds_pkg::TEMP_W;
  localparam int PW = hds_pkg::PCT_W;
  localparam logic signed [TW-1:0] EMERG_T = TW'(EMERGENCY_LOW);
  localparam logic signed [TW-1:0] CRIT_T  = TW'(CRITICAL_LOW);

  // ---------------------------------------------------------------- registers
  logic                  heating_enabled;
  logic signed [TW-1:0]  temp_min, temp_max;
  logic [PW-1:0]         pump_min, pump_max, fan_min, fan_max;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      heating_enabled <= hds_pkg::RST_HEAT_EN;
      temp_min        <= hds_pkg::RST_TEMP_MIN;
      temp_max        <= hds_pkg::RST_TEMP_MAX;
      pump_min        <= hds_pkg::RST_PUMP_MIN;
      pump_max        <= hds_pkg::RST_PUMP_MAX;
      fan_min         <= hds_pkg::RST_FAN_MIN;
      fan_max         <= hds_pkg::RST_FAN_MAX;
    end else if (cfg_wr) begin
      unique case (hds_pkg::reg_idx_t'(paddr[4:2]))
        hds_pkg::REG_HEAT_EN:  heating_enabled <= pwdata[0];
        hds_pkg::REG_TEMP_MIN: temp_min        <= pwdata[TW-1:0];
        hds_pkg::REG_TEMP_MAX: temp_max        <= pwdata[TW-1:0];
        hds_pkg::REG_PUMP_MIN: pump_min        <= pwdata[PW-1:0];
        hds_pkg::REG_PUMP_MAX: pump_max        <= pwdata[PW-1:0];
        hds_pkg::REG_FAN_MIN:  fan_min         <= pwdata[PW-1:0];
        hds_pkg::REG_FAN_MAX:  fan_max         <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hds_pkg::reg_idx_t'(paddr[4:2]))
      hds_pkg::REG_HEAT_EN:  prdata = 32'(heating_enabled);
      hds_pkg::REG_TEMP_MIN: prdata = 32'(temp_min);   // sign-extended
      hds_pkg::REG_TEMP_MAX: prdata = 32'(temp_max);
      hds_pkg::REG_PUMP_MIN: prdata = 32'(pump_min);
      hds_pkg::REG_PUMP_MAX: prdata = 32'(pump_max);
      hds_pkg::REG_FAN_MIN:  prdata = 32'(fan_min);
      hds_pkg::REG_FAN_MAX:  prdata = 32'(fan_max);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  hds_pkg::sched_state_t state, state_next;
  hds_pkg::op_t          op_r;
  logic signed [TW-1:0]  t_r;
  logic manual_latch, manual_latch_next;
  logic force_latch, force_latch_next;
  logic emergency_latch, emergency_latch_next;
  logic win_mode, win_mode_next;     // window ramp: clamps apply, fan base is 40
  logic pump_neg, pump_neg_next;
  logic fan_neg, fan_neg_next;
  logic          res_drive, res_drive_next;
  logic [PW-1:0] res_pump, res_pump_next;
  logic [PW-1:0] res_fan, res_fan_next;
  logic          in_acc, out_free, out_load;
  logic          decide_sample;

  hds_pkg::md_req_t a_req, b_req;
  hds_pkg::md_rsp_t a_rsp, b_rsp;

  // unit A: window position, then pump ramp. Unit B: fan ramp.
  hds_muldiv u_md_a (.clk(clk), .rst(rst), .req(a_req), .rsp(a_rsp));
  hds_muldiv u_md_b (.clk(clk), .rst(rst), .req(b_req), .rsp(b_rsp));

  assign in_stall = (state != hds_pkg::S_IDLE);
  assign in_acc   = in_valid && (state == hds_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == hds_pkg::S_WRITE) && out_free;
  assign decide_sample = (state == hds_pkg::S_DECIDE) && (op_r == hds_pkg::OP_SAMPLE);

  // ---------------------------------------------------------------- datapath
  logic signed [TW:0]  deficit, span, offset;
  logic [TW-1:0]       d_clamp;
  logic signed [7:0]   pdiff, fdiff, fwdiff, pdiff_neg, fdiff_neg, fwdiff_neg;
  logic [PW-1:0]       pmag, fmag, fwmag, pump_drop;
  logic                below, above;
  logic [8:0]          qa_s, qb_s;
  logic signed [8:0]   p9, f9, half9, pmin9, fmin9, fbase9;
  logic [PW-1:0]       pump_fin, fan_fin;

  assign deficit = {temp_min[TW-1], temp_min} - {t_r[TW-1], t_r};
  assign span    = {temp_max[TW-1], temp_max} - {temp_min[TW-1], temp_min};
  assign offset  = {t_r[TW-1], t_r} - {temp_min[TW-1], temp_min};
  assign below   = t_r < temp_min;
  assign above   = t_r > temp_max;
  assign d_clamp = (deficit > $signed({1'b0, hds_pkg::DEFICIT_MAX}))
                   ? hds_pkg::DEFICIT_MAX : deficit[TW-1:0];

  assign pdiff      = $signed({1'b0, pump_max}) - $signed({1'b0, pump_min});
  assign fdiff      = $signed({1'b0, fan_max}) - $signed({1'b0, fan_min});
  assign fwdiff     = $signed({1'b0, fan_min}) - $signed({1'b0, hds_pkg::FAN_WIN_TOP});
  assign pdiff_neg  = -pdiff;
  assign fdiff_neg  = -fdiff;
  assign fwdiff_neg = -fwdiff;
  assign pmag       = pdiff[7]  ? pdiff_neg[PW-1:0]  : pdiff[PW-1:0];
  assign fmag       = fdiff[7]  ? fdiff_neg[PW-1:0]  : fdiff[PW-1:0];
  assign fwmag      = fwdiff[7] ? fwdiff_neg[PW-1:0] : fwdiff[PW-1:0];
  // pump_min/2 - pump_min, as a magnitude
  assign pump_drop  = pump_min - {1'b0, pump_min[PW-1:1]};

  // ramp results: base +/- quotient, truncated toward zero
  assign qa_s   = pump_neg ? (9'd0 - {1'b0, a_rsp.q[7:0]}) : {1'b0, a_rsp.q[7:0]};
  assign qb_s   = fan_neg  ? (9'd0 - {1'b0, b_rsp.q[7:0]}) : {1'b0, b_rsp.q[7:0]};
  assign pmin9  = $signed({2'b00, pump_min});
  assign fmin9  = $signed({2'b00, fan_min});
  assign half9  = $signed({3'b000, pump_min[PW-1:1]});
  assign fbase9 = win_mode ? $signed({2'b00, hds_pkg::FAN_WIN_TOP}) : fmin9;
  assign p9     = pmin9 + $signed(qa_s);
  assign f9     = fbase9 + $signed(qb_s);

  always_comb begin
    pump_fin = p9[PW-1:0];
    fan_fin  = f9[PW-1:0];
    if (win_mode) begin
      priority if (p9 < half9) pump_fin = pump_min >> 1;
      else if (p9 > pmin9)     pump_fin = pump_min;
      priority if (f9 < fmin9) fan_fin = fan_min;
      else if (f9 > $signed({2'b00, hds_pkg::FAN_WIN_TOP})) fan_fin = hds_pkg::FAN_WIN_TOP;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= hds_pkg::S_IDLE;
      manual_latch    <= 1'b0;
      force_latch     <= 1'b0;
      emergency_latch <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      manual_latch    <= manual_latch_next;
      force_latch     <= force_latch_next;
      emergency_latch <= emergency_latch_next;
      if (out_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (in_acc) begin
      op_r <= hds_pkg::op_t'(op);
      t_r  <= temp_room;
    end
    win_mode  <= win_mode_next;
    pump_neg  <= pump_neg_next;
    fan_neg   <= fan_neg_next;
    res_drive <= res_drive_next;
    res_pump  <= res_pump_next;
    res_fan   <= res_fan_next;
    if (out_load) begin
      drive_valid    <= res_drive;
      pump_percent   <= res_pump;
      fan_percent    <= res_fan;
      manual_flag    <= manual_latch;
      force_flag     <= force_latch;
      emergency_flag <= emergency_latch;
    end
  end

  always_comb begin
    state_next           = state;
    manual_latch_next    = manual_latch;
    force_latch_next     = force_latch;
    emergency_latch_next = emergency_latch;
    win_mode_next        = win_mode;
    pump_neg_next        = pump_neg;
    fan_neg_next         = fan_neg;
    res_drive_next       = res_drive;
    res_pump_next        = res_pump;
    res_fan_next         = res_fan;
    a_req                = '0;
    b_req                = '0;
    unique case (state)
      hds_pkg::S_IDLE: begin
        if (in_acc) state_next = hds_pkg::S_DECIDE;
      end
      hds_pkg::S_DECIDE: begin
        res_drive_next = 1'b0;
        res_pump_next  = '0;
        res_fan_next   = '0;
        state_next     = hds_pkg::S_WRITE;
        unique case (op_r)
          hds_pkg::OP_AUTO: begin
            manual_latch_next    = 1'b0;
            force_latch_next     = 1'b0;
            emergency_latch_next = 1'b0;
          end
          hds_pkg::OP_MANUAL: begin
            manual_latch_next = 1'b1;
            force_latch_next  = 1'b0;
          end
          hds_pkg::OP_FORCE: begin
            force_latch_next  = 1'b1;
            manual_latch_next = 1'b0;
          end
          hds_pkg::OP_SAMPLE: begin
            if (!manual_latch && !force_latch && !emergency_latch && heating_enabled) begin
              res_drive_next = 1'b1;
              priority if (t_r <= EMERG_T) begin
                emergency_latch_next = 1'b1;
                res_pump_next        = hds_pkg::PCT_FULL;
                res_fan_next         = hds_pkg::PCT_FULL;
              end else if (t_r <= CRIT_T) begin
                force_latch_next = 1'b1;
                res_pump_next    = hds_pkg::PCT_CRIT;
                res_fan_next     = hds_pkg::PCT_CRIT;
              end else if (below) begin
                // deficit ramp over 0..20 tenths
                win_mode_next = 1'b0;
                pump_neg_next = pdiff[7];
                fan_neg_next  = fdiff[7];
                a_req = '{start: 1'b1, a: d_clamp, b: pmag, c: hds_pkg::DEFICIT_MAX};
                b_req = '{start: 1'b1, a: d_clamp, b: fmag, c: hds_pkg::DEFICIT_MAX};
                state_next = hds_pkg::S_LERP;
              end else if (above) begin
                res_pump_next = '0;
                res_fan_next  = fan_min;
              end else begin
                win_mode_next = 1'b1;
                pump_neg_next = 1'b1;
                fan_neg_next  = fwdiff[7];
                if (span == '0) begin
                  // degenerate window: position is zero, go straight to the ramps
                  a_req = '{start: 1'b1, a: '0, b: pump_drop, c: hds_pkg::WIN_DIV};
                  b_req = '{start: 1'b1, a: '0, b: fwmag, c: hds_pkg::WIN_DIV};
                  state_next = hds_pkg::S_LERP;
                end else begin
                  a_req = '{start: 1'b1, a: offset[TW-1:0], b: hds_pkg::WIN_SCALE,
                            c: span[TW-1:0]};
                  state_next = hds_pkg::S_WIN;
                end
              end
            end
          end
        endcase
      end
      hds_pkg::S_WIN: begin
        if (a_rsp.done) begin
          // position 0..100 in the low bits
          a_req = '{start: 1'b1, a: TW'(a_rsp.q[6:0]), b: pump_drop, c: hds_pkg::WIN_DIV};
          b_req = '{start: 1'b1, a: TW'(a_rsp.q[6:0]), b: fwmag, c: hds_pkg::WIN_DIV};
          state_next = hds_pkg::S_LERP;
        end
      end
      hds_pkg::S_LERP: begin
        if (a_rsp.done) begin
          res_pump_next = pump_fin;
          res_fan_next  = fan_fin;
          state_next    = hds_pkg::S_WRITE;
        end
      end
      hds_pkg::S_WRITE: begin
        if (out_free) state_next = hds_pkg::S_IDLE;
      end
      default: state_next = hds_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- checks
  `HDS_ASSERT_NOW(a_units_in_step, state == hds_pkg::S_LERP, a_rsp.done == b_rsp.done)
  `HDS_ASSERT_NOW(a_out_from_write, $rose(out_valid), $past(state) == hds_pkg::S_WRITE)
  `HDS_ASSERT_NOW(a_emerg_by_sample, $rose(emergency_latch), $past(decide_sample))

endmodule

@@ rtl/hds_muldiv.sv @@
// Bit-serial unsigned multiply then divide: q = trunc(a * b / c).
// Depends on hds_pkg. One multiplier bit per cycle, then one quotient bit per cycle.
module hds_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  hds_pkg::md_req_t req,
  output hds_pkg::md_rsp_t rsp
);

  hds_pkg::md_phase_t                phase, phase_next;
  logic [hds_pkg::CNT_W-1:0]         cnt, cnt_next;
  logic [hds_pkg::NUM_W-1:0]         acc, acc_next;
  logic [hds_pkg::NUM_W-1:0]         mcand, mcand_next;
  logic [hds_pkg::MPL_W-1:0]         mplier, mplier_next;
  logic [hds_pkg::DIV_W-1:0]         divisor, divisor_next;
  logic [hds_pkg::DIV_W-1:0]         rem, rem_next;
  logic                              done, done_next;
  logic [hds_pkg::DIV_W:0]           rem_sh, rem_diff;
  logic                              ge;

  assign rem_sh   = {rem, acc[hds_pkg::NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign ge       = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hds_pkg::MD_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= done_next;
    end
    cnt     <= cnt_next;
    acc     <= acc_next;
    mcand   <= mcand_next;
    mplier  <= mplier_next;
    divisor <= divisor_next;
    rem     <= rem_next;
  end

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    acc_next     = acc;
    mcand_next   = mcand;
    mplier_next  = mplier;
    divisor_next = divisor;
    rem_next     = rem;
    done_next    = 1'b0;
    unique case (phase)
      hds_pkg::MD_IDLE: begin
        if (req.start) begin
          phase_next   = hds_pkg::MD_MUL;
          acc_next     = '0;
          mcand_next   = hds_pkg::NUM_W'(req.a);
          mplier_next  = req.b;
          divisor_next = req.c;
          cnt_next     = '0;
        end
      end
      hds_pkg::MD_MUL: begin
        acc_next    = acc + (mplier[0] ? mcand : '0);
        mcand_next  = {mcand[hds_pkg::NUM_W-2:0], 1'b0};
        mplier_next = {1'b0, mplier[hds_pkg::MPL_W-1:1]};
        cnt_next    = cnt + 1'b1;
        if (cnt == hds_pkg::CNT_W'(hds_pkg::MPL_W - 1)) begin
          phase_next = hds_pkg::MD_DIV;
          cnt_next   = '0;
          rem_next   = '0;
        end
      end
      hds_pkg::MD_DIV: begin
        // restoring step; the quotient bit shifts into the low end of acc
        rem_next = ge ? rem_diff[hds_pkg::DIV_W-1:0] : rem_sh[hds_pkg::DIV_W-1:0];
        acc_next = {acc[hds_pkg::NUM_W-2:0], ge};
        cnt_next = cnt + 1'b1;
        if (cnt == hds_pkg::CNT_W'(hds_pkg::NUM_W - 1)) begin
          phase_next = hds_pkg::MD_IDLE;
          done_next  = 1'b1;
        end
      end
      default: phase_next = hds_pkg::MD_IDLE;
    endcase
  end

  assign rsp.done = done;
  assign rsp.q    = acc;

endmodule

@@ tb/sv/heating_drive_scheduler_tb.sv @@
// Self-checking testbench for heating_drive_scheduler: mode commands and temperature
// samples in, drive words out, each checked against an in-bench scheduler model.
// Depends on hds_pkg and the heating_drive_scheduler RTL only.
`timescale 1ns / 100ps

module heating_drive_scheduler_tb;

  localparam int EMERG_T     = 50;    // emergency threshold, tenths of a degree
  localparam int CRIT_T      = 100;   // critical threshold
  localparam int TEMP_LO     = -400;  // sensor range
  localparam int TEMP_HI     = 1250;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES = 80;    // above the slowest word (two muldiv passes)
  localparam int WATCHDOG    = 3000;  // cycles with no word moving on either side
  localparam int SHOW_MAX    = 10;

  typedef struct {
    hds_pkg::op_t                      op;
    logic signed [hds_pkg::TEMP_W-1:0] temp;
  } sched_word_t;

  typedef struct packed {
    logic                      dv;
    logic [hds_pkg::PCT_W-1:0] pump;
    logic [hds_pkg::PCT_W-1:0] fan;
    logic                      man;
    logic                      frc;
    logic                      emg;
  } drive_word_t;

  // ------------------------------------------------------------------------
  // DUT connections; every input has a known value from time zero
  // ------------------------------------------------------------------------
  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              psel      = 1'b0;
  logic                              penable   = 1'b0;
  logic                              pwrite    = 1'b0;
  logic [hds_pkg::ADDR_W-1:0]        paddr     = '0;
  logic [hds_pkg::DATA_W-1:0]        pwdata    = '0;
  logic [hds_pkg::DATA_W-1:0]        prdata;
  logic                              pready;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic [1:0]                        op        = hds_pkg::OP_SAMPLE;
  logic signed [hds_pkg::TEMP_W-1:0] temp_room = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              drive_valid;
  logic [hds_pkg::PCT_W-1:0]         pump_percent;
  logic [hds_pkg::PCT_W-1:0]         fan_percent;
  logic                              manual_flag;
  logic                              force_flag;
  logic                              emergency_flag;

  heating_drive_scheduler #(
    .EMERGENCY_LOW (EMERG_T),
    .CRITICAL_LOW  (CRIT_T)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .temp_room      (temp_room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_valid    (drive_valid),
    .pump_percent   (pump_percent),
    .fan_percent    (fan_percent),
    .manual_flag    (manual_flag),
    .force_flag     (force_flag),
    .emergency_flag (emergency_flag)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // Scheduler model: register copy and mode latches
  // ------------------------------------------------------------------------
  bit cfg_heat = 1'b1;
  int cfg_tmin = 250;
  int cfg_tmax = 260;
  int cfg_pmin = 20;
  int cfg_pmax = 100;
  int cfg_fmin = 20;
  int cfg_fmax = 100;
  bit man_l    = 1'b0;
  bit frc_l    = 1'b0;
  bit emg_l    = 1'b0;

  // Works out the result word for one accepted word and moves the latches on.
  function automatic drive_word_t schedule_word(hds_pkg::op_t wop, int t);
    drive_word_t r;
    int pump, fan, d, x, span, half;
    pump = 0;
    fan  = 0;
    r.dv = 1'b0;
    case (wop)
      hds_pkg::OP_AUTO: begin
        man_l = 1'b0;
        frc_l = 1'b0;
        emg_l = 1'b0;
      end
      hds_pkg::OP_MANUAL: begin
        man_l = 1'b1;
        frc_l = 1'b0;
      end
      hds_pkg::OP_FORCE: begin
        frc_l = 1'b1;
        man_l = 1'b0;
      end
      default: begin
        // a sample drives only in auto with heating on and no latch set
        if (!man_l && !frc_l && !emg_l && cfg_heat) begin
          r.dv = 1'b1;
          if (t <= EMERG_T) begin
            emg_l = 1'b1;
            pump  = 100;
            fan   = 100;
          end else if (t <= CRIT_T) begin
            frc_l = 1'b1;
            pump  = 80;
            fan   = 80;
          end else if (t < cfg_tmin) begin
            // deficit ramp, capped at two degrees
            d = cfg_tmin - t;
            if (d > 20) d = 20;
            pump = d * (cfg_pmax - cfg_pmin) / 20 + cfg_pmin;
            fan  = d * (cfg_fmax - cfg_fmin) / 20 + cfg_fmin;
          end else if (t > cfg_tmax) begin
            pump = 0;
            fan  = cfg_fmin;
          end else begin
            // comfort window: position 0..100, zero for an empty window
            span = cfg_tmax - cfg_tmin;
            half = cfg_pmin / 2;
            x    = 0;
            if (span > 0) x = (t - cfg_tmin) * 100 / span;
            pump = x * (half - cfg_pmin) / 100 + cfg_pmin;
            fan  = x * (cfg_fmin - 40) / 100 + 40;
            if (pump < half) pump = half;
            else if (pump > cfg_pmin) pump = cfg_pmin;
            if (fan < cfg_fmin) fan = cfg_fmin;
            else if (fan > 40) fan = 40;
          end
        end
      end
    endcase
    r.pump = pump[hds_pkg::PCT_W-1:0];
    r.fan  = fan[hds_pkg::PCT_W-1:0];
    r.man  = man_l;
    r.frc  = frc_l;
    r.emg  = emg_l;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // ------------------------------------------------------------------------
  sched_word_t pend_q[$];     // words waiting to be offered
  drive_word_t drive_q[$];    // result words still owed by the block
  int  send_gap_pct = 0;      // chance of an idle cycle on the input side
  int  stall_pct    = 0;      // chance of a stall cycle on the output side
  int  hold_seq     = 0;      // bumped to ask the receiver for a long hold-off
  int  hold_seen    = 0;
  int  hold_left    = 0;
  bit  in_acc       = 1'b0;   // a word was taken at the last rising edge
  int  err_cnt      = 0;
  int  idle_cycles  = 0;
  int  words_in     = 0;
  int  results_seen = 0;
  int  drives_seen  = 0;
  int  cfg_sets     = 0;

  // ------------------------------------------------------------------------
  // Driver: offers words from pend_q, changes inputs at the falling edge.
  // A word that was not taken stays on the pins unchanged.
  // ------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    sched_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        w = pend_q.pop_front();
        in_valid  <= 1'b1;
        op        <= w.op;
        temp_room <= w.temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: predicts on input acceptance, checks on output acceptance,
  // and runs the watchdog. Everything sampled at the rising edge.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    drive_word_t want, got;
    in_acc <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        drive_q.push_back(schedule_word(hds_pkg::op_t'(op), int'(temp_room)));
        words_in++;
      end
      if (out_valid && !out_stall) begin
        got = {drive_valid, pump_percent, fan_percent, manual_flag, force_flag,
               emergency_flag};
        results_seen++;
        if (drive_valid) drives_seen++;
        if (drive_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("%0t: result word with nothing owed: dv=%0b pump=%0d fan=%0d",
                     $realtime, drive_valid, pump_percent, fan_percent);
        end else begin
          want = drive_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX)
              $display({"%0t: word %0d mismatch: expected dv=%0b pump=%0d fan=%0d ",
                        "m/f/e=%0b%0b%0b, got dv=%0b pump=%0d fan=%0d m/f/e=%0b%0b%0b"},
                       $realtime, results_seen, want.dv, want.pump, want.fan,
                       want.man, want.frc, want.emg, got.dv, got.pump, got.fan,
                       got.man, got.frc, got.emg);
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog, no word moved for %0d cycles, %0d still owed",
                 $realtime, WATCHDOG, drive_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic push_word(hds_pkg::op_t wop, int t);
    sched_word_t w;
    w.op   = wop;
    w.temp = t[hds_pkg::TEMP_W-1:0];
    pend_q.push_back(w);
  endtask

  // Sample value: mostly around the comfort window, some near the alarm
  // thresholds, some anywhere in the sensor range.
  function automatic int pick_temp();
    int lo, hi, t;
    lo = ((cfg_tmin < cfg_tmax) ? cfg_tmin : cfg_tmax) - 30;
    hi = ((cfg_tmin < cfg_tmax) ? cfg_tmax : cfg_tmin) + 10;
    case ($urandom_range(9))
      0, 1:    t = int'($urandom_range(TEMP_HI - TEMP_LO)) + TEMP_LO;
      2:       t = 40 + int'($urandom_range(70));
      default: t = lo + int'($urandom_range(hi - lo));
    endcase
    if (t < TEMP_LO) t = TEMP_LO;
    else if (t > TEMP_HI) t = TEMP_HI;
    return t;
  endfunction

  // percent register value, now and then beyond 100 to the 7 bit limit
  function automatic int pick_pct();
    return ($urandom_range(4) == 0) ? int'($urandom_range(127)) : int'($urandom_range(100));
  endfunction

  // Register write in a setup step, then an access step; lands when pready is high.
  task automatic reg_write(hds_pkg::reg_idx_t idx, int value);
    logic signed [hds_pkg::TEMP_W-1:0] v12;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    v12 = value[hds_pkg::TEMP_W-1:0];
    case (idx)
      hds_pkg::REG_HEAT_EN:  cfg_heat = value[0];
      hds_pkg::REG_TEMP_MIN: cfg_tmin = v12;
      hds_pkg::REG_TEMP_MAX: cfg_tmax = v12;
      hds_pkg::REG_PUMP_MIN: cfg_pmin = value & 127;
      hds_pkg::REG_PUMP_MAX: cfg_pmax = value & 127;
      hds_pkg::REG_FAN_MIN:  cfg_fmin = value & 127;
      hds_pkg::REG_FAN_MAX:  cfg_fmax = value & 127;
      default: ;
    endcase
  endtask

  task automatic configure(bit heat, int tmin, int tmax, int pmin, int pmax,
                           int fmin, int fmax);
    reg_write(hds_pkg::REG_HEAT_EN, heat);
    reg_write(hds_pkg::REG_TEMP_MIN, tmin);
    reg_write(hds_pkg::REG_TEMP_MAX, tmax);
    reg_write(hds_pkg::REG_PUMP_MIN, pmin);
    reg_write(hds_pkg::REG_PUMP_MAX, pmax);
    reg_write(hds_pkg::REG_FAN_MIN, fmin);
    reg_write(hds_pkg::REG_FAN_MAX, fmax);
    cfg_sets++;
  endtask

  // Sender stays quiet until every owed result word has come back.
  // Every word yields a result, so an empty drive_q means the block is idle.
  // Checked at the rising edge, where the driver's pins have settled.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || drive_q.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    int ph, n, r, tmin, tmax;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words under reset settings (window 25.0 .. 26.0).
    push_word(hds_pkg::OP_SAMPLE, 255);      // inside the window
    push_word(hds_pkg::OP_SAMPLE, 250);      // lower edge of the window
    push_word(hds_pkg::OP_SAMPLE, 260);      // upper edge
    push_word(hds_pkg::OP_SAMPLE, 261);      // just above: pump off
    push_word(hds_pkg::OP_SAMPLE, 249);      // small deficit
    push_word(hds_pkg::OP_SAMPLE, 200);      // deficit capped
    push_word(hds_pkg::OP_SAMPLE, TEMP_HI);
    push_word(hds_pkg::OP_SAMPLE, CRIT_T + 1);
    push_word(hds_pkg::OP_SAMPLE, CRIT_T);   // critical: force latch set
    push_word(hds_pkg::OP_SAMPLE, 150);      // ignored while forced
    push_word(hds_pkg::OP_AUTO, pick_temp());
    push_word(hds_pkg::OP_SAMPLE, EMERG_T);  // emergency latch set
    push_word(hds_pkg::OP_MANUAL, pick_temp());  // emergency survives manual and force
    push_word(hds_pkg::OP_FORCE, pick_temp());
    push_word(hds_pkg::OP_SAMPLE, 300);
    push_word(hds_pkg::OP_AUTO, pick_temp());
    push_word(hds_pkg::OP_SAMPLE, TEMP_LO);
    push_word(hds_pkg::OP_AUTO, pick_temp());
    push_word(hds_pkg::OP_MANUAL, pick_temp());
    push_word(hds_pkg::OP_SAMPLE, 255);      // ignored in manual
    push_word(hds_pkg::OP_AUTO, pick_temp());
    push_word(hds_pkg::OP_SAMPLE, EMERG_T + 1);
    push_word(hds_pkg::OP_AUTO, pick_temp());
    drain();

    // heating switched off: samples give no drive
    configure(1'b0, 250, 260, 20, 100, 20, 100);
    push_word(hds_pkg::OP_SAMPLE, 255);
    push_word(hds_pkg::OP_SAMPLE, 20);

    // Random phases, each with its settings and one of four idling patterns.
    for (ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: configure(1'b1, TEMP_LO, TEMP_HI, 0, 100, 0, 100);
        1: configure(1'b1, 300, 300, 127, 0, 127, 0);   // empty window, reversed ramps
        2: configure(1'b1, 500, 200, 100, 0, 0, 127);   // limits the wrong way round
        3: configure(1'b0, 250, 260, 20, 100, 20, 100);
        default: begin
          tmin = int'($urandom_range(TEMP_HI - TEMP_LO)) + TEMP_LO;
          tmax = tmin + int'($urandom_range(90)) - 10;
          if (tmax > TEMP_HI) tmax = TEMP_HI;
          configure(1'b1, tmin, tmax, pick_pct(), pick_pct(), pick_pct(), pick_pct());
        end
      endcase
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 54; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 54; end
        default: begin send_gap_pct = 25; stall_pct = 25; end
      endcase
      n = (ph == 3) ? 30 : 150;
      repeat (n) begin
        // auto often enough that the latches do not lock the drive out for long
        r = $urandom_range(99);
        if (r < 68)      push_word(hds_pkg::OP_SAMPLE, pick_temp());
        else if (r < 88) push_word(hds_pkg::OP_AUTO, pick_temp());
        else if (r < 94) push_word(hds_pkg::OP_MANUAL, pick_temp());
        else             push_word(hds_pkg::OP_FORCE, pick_temp());
      end
      // long receiver hold-off while the sender keeps offering: block backs up
      if (ph == 4) hold_seq++;
    end
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    err_cnt += drive_q.size();
    $display("Summary: %0d words in, %0d result words checked, %0d of them drive commands,",
             words_in, results_seen, drives_seen);
    $display("         %0d register settings, %0d failures", cfg_sets, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
